// ===== design/itr_pkg.sv =====
// Shared types, constants and the arctangent table for the impedance-to-reflection block.
package itr_pkg;

  // CORDIC datapath widths
  localparam int CW_W  = 34;
  localparam int ANG_W = 27;
  localparam int ATAN_N = 24;

  // Quotient bits of every divider (8 integer + 16 fraction; 16 integer + 8 fraction for VSWR)
  localparam int QW = 24;

  // Log2 unit: one entry stage plus one squaring cell per fraction bit
  localparam int LOG_FRAC = 16;
  localparam int LOG_LAT  = LOG_FRAC + 1;

  typedef logic [21:0] atan_t;

  // Arctangent of 2^-i in Q16.16 degrees
  localparam atan_t ATAN_DEG [ATAN_N] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG360 = 27'sd23592960;

  localparam logic [23:0]        MAX24      = 24'hFFFFFF;
  localparam logic [24:0]        Q_OVER     = 25'h1000000;
  localparam logic signed [19:0] DB_PER_OCT = 20'sd394566;
  localparam logic [31:0]        Z0_RESET   = 32'd3276800;
  localparam logic [16:0]        ONE_Q16    = 17'h10000;

  localparam logic signed [15:0] S11_MIN = 16'sh8000;
  localparam logic signed [15:0] RL_MAX  = 16'sh7FFF;

  // Clipped gamma component
  typedef struct packed {
    logic signed [23:0] val;
    logic               sat;
  } itr_gclip_t;

  // Per-transaction results gathered ahead of the VSWR divider
  typedef struct packed {
    logic               inval;
    logic signed [23:0] gre;
    logic signed [23:0] gim;
    logic [23:0]        mag;
    logic signed [24:0] phase;
    logic               pm;
    logic               inf;
    logic               sat;
  } itr_res_t;

endpackage

// ===== design/impedance_to_reflection.sv =====
// Top level: load impedance to gamma, magnitude, phase, S11, return loss and VSWR.
//
// Input channel (in_valid/in_ready) carries a load R + jX, both signed Q16.16 ohms.
// Result channel (out_valid/out_ready) carries one result transaction per input.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the reference impedance
// Z0, unsigned Q16.16 ohms; cfg_ready is always high. Write it only while idle.
// Throughput: one transaction per cycle unless the output register is full and stalled.
// From acceptance to out_valid a transaction passes the chain: prescale, product
// and sum stages, the CORDIC cells, the 25-stage magnitude divider and the 25-stage
// VSWR divider in series.
// A stalled receiver holds the result in the output register; the pipeline keeps
// taking transactions while its last stage is empty and freezes once it is full.
// Reset clears all valid state and sets Z0 to 50 ohms; the output channel is empty.
// A zero Z0, or a load of exactly -Z0 with no reactance, yields a result with
// result_valid low and every other field zero.
module impedance_to_reflection #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_load_resistance,
  input  logic signed [31:0] in_load_reactance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_result_valid,
  output logic signed [23:0] out_gamma_real,
  output logic signed [23:0] out_gamma_imag,
  output logic [23:0]        out_gamma_magnitude,
  output logic signed [24:0] out_phase_degrees,
  output logic signed [15:0] out_s11_db,
  output logic signed [15:0] out_return_loss_db,
  output logic [23:0]        out_vswr_value,
  output logic               out_vswr_infinite,
  output logic               out_perfect_match,
  output logic               out_saturated
);

  import itr_pkg::*;

  localparam int DIV_LAT = QW + 1;
  localparam int ST_CORD = 2 + CORDIC_STAGES + 1;
  localparam int ST_PH   = ST_CORD + 1;
  localparam int ST_MDIV = ST_CORD + DIV_LAT;
  localparam int ST_P1   = ST_MDIV + 1;
  localparam int ST_G    = 5 + DIV_LAT + 1;
  localparam int ST_VDIV = ST_P1 + DIV_LAT;
  localparam int ST_S11  = ST_P1 + LOG_LAT + 1;
  localparam int LAT     = ST_VDIV;

  // ---------------------------------------------------------------- control
  logic [31:0]    z0_r;
  logic [LAT-1:0] vld_r;
  logic           out_valid_r;
  logic           out_take;
  logic           en;

  assign out_take  = !out_valid_r || out_ready;
  assign en        = out_take || !vld_r[LAT-1];
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  // Hold the reference impedance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z0_r <= Z0_RESET;
    end else if (cfg_valid) begin
      z0_r <= cfg_data;
    end
  end

  // Advance the valid chain with the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic signed [33:0] n1_nxt, d1_nxt, n1_r, d1_r;
  logic signed [31:0] x1_r;
  logic               inv1_nxt, inv1_r;

  always_comb begin
    n1_nxt   = 34'(in_load_resistance) - $signed({2'b00, z0_r});
    d1_nxt   = 34'(in_load_resistance) + $signed({2'b00, z0_r});
    inv1_nxt = (z0_r == '0) || ((d1_nxt == '0) && (in_load_reactance == '0));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r   <= n1_nxt;
      d1_r   <= d1_nxt;
      x1_r   <= in_load_reactance;
      inv1_r <= inv1_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2: prescale
  function automatic logic signed [30:0] shrink(input logic [33:0] mag, input logic neg,
                                                input logic [2:0] sh);
    logic [33:0] m;
    logic [30:0] v;
    m = mag >> sh;
    v = m[30:0];
    return neg ? $signed(-v) : $signed(v);
  endfunction

  logic [33:0]        an, ad, ax, orv;
  logic [2:0]         sh;
  logic signed [30:0] n2_nxt, d2_nxt, x2_nxt, n2_r, d2_r, x2_r;
  logic               inv2_r;

  always_comb begin
    an  = n1_r[33] ? 34'(-n1_r) : 34'(n1_r);
    ad  = d1_r[33] ? 34'(-d1_r) : 34'(d1_r);
    ax  = x1_r[31] ? 34'(-34'(x1_r)) : 34'(x1_r);
    orv = an | ad | ax;
    if (orv[33]) begin
      sh = 3'd4;
    end else if (orv[32]) begin
      sh = 3'd3;
    end else if (orv[31]) begin
      sh = 3'd2;
    end else if (orv[30]) begin
      sh = 3'd1;
    end else begin
      sh = 3'd0;
    end
    n2_nxt = shrink(an, n1_r[33], sh);
    d2_nxt = shrink(ad, d1_r[33], sh);
    x2_nxt = shrink(ax, x1_r[31], sh);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r   <= n2_nxt;
      d2_r   <= d2_nxt;
      x2_r   <= x2_nxt;
      inv2_r <= inv1_r;
    end
  end

  // ---------------------------------------------------------------- stages 3-5: gamma terms
  logic signed [61:0] p_nd_r, p_xx_r, p_dd_r, p_xd_r, p_nx_r;
  logic signed [62:0] nre_r, nim_r, den_r;
  logic [62:0]        are_r, aim_r;
  logic [61:0]        dd5_r;
  logic [1:0]         sgn5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_nd_r <= n2_r * d2_r;
      p_xx_r <= x2_r * x2_r;
      p_dd_r <= d2_r * d2_r;
      p_xd_r <= x2_r * d2_r;
      p_nx_r <= n2_r * x2_r;
      nre_r  <= 63'(p_nd_r) + 63'(p_xx_r);
      nim_r  <= 63'(p_xd_r) - 63'(p_nx_r);
      den_r  <= 63'(p_dd_r) + 63'(p_xx_r);
      are_r  <= nre_r[62] ? 63'(-nre_r) : 63'(nre_r);
      aim_r  <= nim_r[62] ? 63'(-nim_r) : 63'(nim_r);
      dd5_r  <= den_r[61:0];
      sgn5_r <= {nre_r[62], nim_r[62]};
    end
  end

  logic [QW-1:0] q_re, q_im;
  logic          s_re, s_im, z_re, z_im;
  logic [1:0]    sgn_d;

  itr_div #(.A_W(79), .B_W(62), .Q_B(QW)) u_div_re (
    .clk(clk), .en(en), .a_in({are_r, 16'h0000}), .b_in(dd5_r),
    .q_out(q_re), .sat_out(s_re), .zero_out(z_re)
  );

  itr_div #(.A_W(79), .B_W(62), .Q_B(QW)) u_div_im (
    .clk(clk), .en(en), .a_in({aim_r, 16'h0000}), .b_in(dd5_r),
    .q_out(q_im), .sat_out(s_im), .zero_out(z_im)
  );

  itr_delay #(.W(2), .D(DIV_LAT)) u_dly_sgn (
    .clk(clk), .en(en), .din(sgn5_r), .dout(sgn_d)
  );

  // Apply sign and clip a gamma component to 24 bits
  function automatic itr_gclip_t gam_clip(input logic [QW-1:0] q, input logic sat,
                                          input logic zero, input logic neg);
    itr_gclip_t r;
    logic [24:0] qf;
    logic [24:0] qn;
    qf = zero ? '0 : (sat ? Q_OVER : {1'b0, q});
    qn = -qf;
    r.sat = 1'b0;
    if (neg) begin
      if (qf > 25'd8388608) begin
        r.val = 24'sh800000;
        r.sat = 1'b1;
      end else begin
        r.val = $signed(qn[23:0]);
      end
    end else begin
      if (qf > 25'd8388607) begin
        r.val = 24'sh7FFFFF;
        r.sat = 1'b1;
      end else begin
        r.val = $signed(qf[23:0]);
      end
    end
    return r;
  endfunction

  itr_gclip_t gre_nxt, gim_nxt, gre_r, gim_r;
  logic [48:0] gam_d;

  always_comb begin
    gre_nxt = gam_clip(q_re, s_re, z_re, sgn_d[1]);
    gim_nxt = gam_clip(q_im, s_im, z_im, sgn_d[0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gre_r <= gre_nxt;
      gim_r <= gim_nxt;
    end
  end

  itr_delay #(.W(49), .D(ST_MDIV - ST_G)) u_dly_gam (
    .clk(clk), .en(en), .din({gre_r.val, gim_r.val, gre_r.sat | gim_r.sat}), .dout(gam_d)
  );

  // ---------------------------------------------------------------- CORDIC and phase
  logic [32:0]             mag_a, mag_b;
  logic signed [ANG_W-1:0] ang_a, ang_b;

  itr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_a (
    .clk(clk), .en(en), .x_in(n2_r), .y_in(x2_r), .mag_out(mag_a), .ang_out(ang_a)
  );

  itr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_b (
    .clk(clk), .en(en), .x_in(d2_r), .y_in(x2_r), .mag_out(mag_b), .ang_out(ang_b)
  );

  logic signed [ANG_W:0] ph_diff;
  logic signed [ANG_W:0] ph_wrap;
  logic signed [24:0]    ph_r, ph_d;

  // Wrap the angle difference into (-180, 180]
  always_comb begin
    ph_diff = (ANG_W+1)'(ang_a) - (ANG_W+1)'(ang_b);
    if (ph_diff > (ANG_W+1)'(DEG180)) begin
      ph_wrap = ph_diff - (ANG_W+1)'(DEG360);
    end else if (ph_diff <= -(ANG_W+1)'(DEG180)) begin
      ph_wrap = ph_diff + (ANG_W+1)'(DEG360);
    end else begin
      ph_wrap = ph_diff;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r <= ph_wrap[24:0];
    end
  end

  itr_delay #(.W(25), .D(ST_MDIV - ST_PH)) u_dly_ph (
    .clk(clk), .en(en), .din(ph_r), .dout(ph_d)
  );

  logic inv_d;

  itr_delay #(.W(1), .D(ST_MDIV - 2)) u_dly_inv (
    .clk(clk), .en(en), .din(inv2_r), .dout(inv_d)
  );

  // ---------------------------------------------------------------- magnitude ratio
  logic [QW-1:0] q_m;
  logic          s_m, z_m;

  itr_div #(.A_W(49), .B_W(33), .Q_B(QW)) u_div_mag (
    .clk(clk), .en(en), .a_in({mag_a, 16'h0000}), .b_in(mag_b),
    .q_out(q_m), .sat_out(s_m), .zero_out(z_m)
  );

  itr_res_t res_nxt, res_r, res_d;

  // Gather everything known before the VSWR divider
  always_comb begin
    res_nxt.inval = inv_d;
    res_nxt.gre   = $signed(gam_d[48:25]);
    res_nxt.gim   = $signed(gam_d[24:1]);
    res_nxt.phase = ph_d;
    if (z_m) begin
      res_nxt.mag = '0;
    end else if (s_m) begin
      res_nxt.mag = MAX24;
    end else begin
      res_nxt.mag = q_m;
    end
    res_nxt.pm  = (res_nxt.mag == '0);
    res_nxt.inf = (res_nxt.mag[23:16] != '0);
    res_nxt.sat = gam_d[0] | (s_m & !z_m);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  itr_delay #(.W($bits(itr_res_t)), .D(DIV_LAT)) u_dly_res (
    .clk(clk), .en(en), .din(res_r), .dout(res_d)
  );

  // ---------------------------------------------------------------- S11
  logic signed [21:0] l_q;
  logic signed [41:0] s11_prod;
  logic signed [15:0] s11_r, s11_d;

  itr_log2 u_log2 (
    .clk(clk), .en(en), .m_in(res_r.mag), .l_out(l_q)
  );

  always_comb begin
    s11_prod = 42'(l_q) * 42'(DB_PER_OCT) + 42'sd8388608;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_r <= $signed(s11_prod[39:24]);
    end
  end

  itr_delay #(.W(16), .D(ST_VDIV - ST_S11)) u_dly_s11 (
    .clk(clk), .en(en), .din(s11_r), .dout(s11_d)
  );

  // ---------------------------------------------------------------- VSWR
  logic [16:0]   vs_num, vs_den;
  logic [QW-1:0] q_v;
  logic          s_v;

  always_comb begin
    vs_num = ONE_Q16 + {1'b0, res_r.mag[15:0]};
    vs_den = ONE_Q16 - {1'b0, res_r.mag[15:0]};
  end

  itr_div #(.A_W(25), .B_W(17), .Q_B(QW)) u_div_vswr (
    .clk(clk), .en(en), .a_in({vs_num, 8'h00}), .b_in(vs_den),
    .q_out(q_v), .sat_out(s_v), .zero_out()
  );

  // ---------------------------------------------------------------- output register
  logic               rv_nxt, rv_r;
  logic signed [23:0] gre_o_nxt, gre_o_r, gim_o_nxt, gim_o_r;
  logic [23:0]        mag_o_nxt, mag_o_r, vswr_nxt, vswr_r;
  logic signed [24:0] ph_o_nxt, ph_o_r;
  logic signed [15:0] s11_o_nxt, s11_o_r, rl_nxt, rl_r;
  logic               inf_nxt, inf_r, pm_nxt, pm_r, sat_nxt, sat_r;

  always_comb begin
    rv_nxt    = 1'b0;
    gre_o_nxt = '0;
    gim_o_nxt = '0;
    mag_o_nxt = '0;
    ph_o_nxt  = '0;
    s11_o_nxt = '0;
    rl_nxt    = '0;
    vswr_nxt  = '0;
    inf_nxt   = 1'b0;
    pm_nxt    = 1'b0;
    sat_nxt   = 1'b0;
    if (!res_d.inval) begin
      rv_nxt    = 1'b1;
      gre_o_nxt = res_d.gre;
      gim_o_nxt = res_d.gim;
      mag_o_nxt = res_d.mag;
      ph_o_nxt  = res_d.phase;
      pm_nxt    = res_d.pm;
      inf_nxt   = res_d.inf;
      s11_o_nxt = res_d.pm ? S11_MIN : s11_d;
      rl_nxt    = res_d.pm ? RL_MAX : -s11_d;
      vswr_nxt  = (res_d.inf || s_v) ? MAX24 : q_v;
      sat_nxt   = res_d.sat | (!res_d.inf & s_v);
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && vld_r[LAT-1]) begin
      rv_r    <= rv_nxt;
      gre_o_r <= gre_o_nxt;
      gim_o_r <= gim_o_nxt;
      mag_o_r <= mag_o_nxt;
      ph_o_r  <= ph_o_nxt;
      s11_o_r <= s11_o_nxt;
      rl_r    <= rl_nxt;
      vswr_r  <= vswr_nxt;
      inf_r   <= inf_nxt;
      pm_r    <= pm_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign out_result_valid    = rv_r;
  assign out_gamma_real      = gre_o_r;
  assign out_gamma_imag      = gim_o_r;
  assign out_gamma_magnitude = mag_o_r;
  assign out_phase_degrees   = ph_o_r;
  assign out_s11_db          = s11_o_r;
  assign out_return_loss_db  = rl_r;
  assign out_vswr_value      = vswr_r;
  assign out_vswr_infinite   = inf_r;
  assign out_perfect_match   = pm_r;
  assign out_saturated       = sat_r;

endmodule

// ===== design/itr_delay.sv =====
// Enabled shift line that carries side data alongside the arithmetic pipeline.
module itr_delay #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] d_r [D];

  // Advance the line whenever the pipeline moves
  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= din;
      for (int k = 1; k < D; k++) begin
        d_r[k] <= d_r[k-1];
      end
    end
  end

  assign dout = d_r[D-1];

endmodule

// ===== design/itr_div.sv =====
// Pipelined restoring divider: one quotient bit per cell, floor(a/b) over QB bits.
module itr_div #(
  parameter int A_W = 79,
  parameter int B_W = 62,
  parameter int Q_B = 24
) (
  input  logic           clk,
  input  logic           en,
  input  logic [A_W-1:0] a_in,
  input  logic [B_W-1:0] b_in,
  output logic [Q_B-1:0] q_out,
  output logic           sat_out,
  output logic           zero_out
);

  localparam int HI_W = A_W - Q_B;
  localparam int CW   = (HI_W > B_W) ? HI_W : B_W;

  logic [B_W-1:0] rem_r  [Q_B+1];
  logic [B_W-1:0] b_r    [Q_B+1];
  logic [Q_B-1:0] tail_r [Q_B+1];
  logic [Q_B-1:0] q_r    [Q_B+1];
  logic           sat_r  [Q_B+1];
  logic           zero_r [Q_B+1];

  logic [CW-1:0]  hi_ext;
  logic [CW-1:0]  b_ext;
  logic           sat_nxt;
  logic           zero_nxt;
  logic [B_W-1:0] rem_nxt;

  // Entry: the top bits form the first partial remainder; overflow if they reach b
  always_comb begin
    hi_ext   = CW'(a_in[A_W-1:Q_B]);
    b_ext    = CW'(b_in);
    zero_nxt = (a_in == '0);
    sat_nxt  = !zero_nxt && (hi_ext >= b_ext);
    rem_nxt  = sat_nxt ? '0 : hi_ext[B_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= rem_nxt;
      b_r[0]    <= b_in;
      tail_r[0] <= a_in[Q_B-1:0];
      q_r[0]    <= '0;
      sat_r[0]  <= sat_nxt;
      zero_r[0] <= zero_nxt;
    end
  end

  // Cells: shift in one dividend bit, subtract the divisor where it fits
  for (genvar j = 0; j < Q_B; j++) begin : g_cell
    logic [B_W:0] trial;
    logic [B_W:0] diff;
    logic         ge;

    always_comb begin
      trial = {rem_r[j], tail_r[j][Q_B-1]};
      diff  = trial - {1'b0, b_r[j]};
      ge    = (trial >= {1'b0, b_r[j]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= ge ? diff[B_W-1:0] : trial[B_W-1:0];
        b_r[j+1]    <= b_r[j];
        tail_r[j+1] <= {tail_r[j][Q_B-2:0], 1'b0};
        q_r[j+1]    <= {q_r[j][Q_B-2:0], ge};
        sat_r[j+1]  <= sat_r[j];
        zero_r[j+1] <= zero_r[j];
      end
    end
  end

  assign q_out    = q_r[Q_B];
  assign sat_out  = sat_r[Q_B];
  assign zero_out = zero_r[Q_B];

endmodule

// ===== design/itr_cordic.sv =====
// CORDIC vectoring chain: magnitude and angle in Q16.16 degrees, one stage per cell.
module itr_cordic #(
  parameter int STAGES = 16
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [30:0]             x_in,
  input  logic signed [30:0]             y_in,
  output logic [32:0]                    mag_out,
  output logic signed [itr_pkg::ANG_W-1:0] ang_out
);

  import itr_pkg::*;

  logic signed [CW_W-1:0]  x_r [STAGES+1];
  logic signed [CW_W-1:0]  y_r [STAGES+1];
  logic signed [ANG_W-1:0] z_r [STAGES+1];
  logic                    zf_r [STAGES+1];

  logic signed [CW_W-1:0] xe;
  logic signed [CW_W-1:0] ye;

  always_comb begin
    xe = CW_W'(x_in);
    ye = CW_W'(y_in);
  end

  // Entry: fold the left half plane over by 180 degrees
  always_ff @(posedge clk) begin
    if (en) begin
      zf_r[0] <= (x_in == '0) && (y_in == '0);
      if (xe < 0) begin
        x_r[0] <= -xe;
        y_r[0] <= -ye;
        z_r[0] <= DEG180;
      end else begin
        x_r[0] <= xe;
        y_r[0] <= ye;
        z_r[0] <= '0;
      end
    end
  end

  // Micro-rotations toward the x axis
  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    localparam logic signed [ANG_W-1:0] AT = ANG_W'(ATAN_DEG[i]);
    logic signed [CW_W-1:0] xs;
    logic signed [CW_W-1:0] ys;

    always_comb begin
      xs = x_r[i] >>> i;
      ys = y_r[i] >>> i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zf_r[i+1] <= zf_r[i];
        if (!y_r[i][CW_W-1]) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + AT;
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - AT;
        end
      end
    end
  end

  // A zero vector reports zero magnitude and zero angle
  assign mag_out = zf_r[STAGES] ? '0 : x_r[STAGES][32:0];
  assign ang_out = zf_r[STAGES] ? '0 : z_r[STAGES];

endmodule

// ===== design/itr_log2.sv =====
// Log2 of a Q8.16 magnitude in Q16: leading-one entry stage, then one squaring cell per bit.
module itr_log2 (
  input  logic               clk,
  input  logic               en,
  input  logic [23:0]        m_in,
  output logic signed [21:0] l_out
);

  import itr_pkg::*;

  logic [23:0]          t_r  [LOG_FRAC+1];
  logic [LOG_FRAC-1:0]  f_r  [LOG_FRAC+1];
  logic signed [5:0]    ip_r [LOG_FRAC+1];

  logic [4:0]  p;
  logic [23:0] t_nxt;

  // Find the leading one and normalise the mantissa to [1,2)
  always_comb begin
    p = '0;
    for (int i = 1; i < 24; i++) begin
      if (m_in[i]) begin
        p = 5'(i);
      end
    end
    t_nxt = m_in << (5'd23 - p);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0]  <= t_nxt;
      f_r[0]  <= '0;
      ip_r[0] <= $signed({1'b0, p}) - 6'sd16;
    end
  end

  // Square the mantissa; an overflow past 2 yields the next fraction bit
  for (genvar j = 0; j < LOG_FRAC; j++) begin : g_cell
    logic [47:0] sq;
    logic [24:0] t2;

    always_comb begin
      sq = t_r[j] * t_r[j];
      t2 = sq[47:23];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t_r[j+1]  <= t2[24] ? t2[24:1] : t2[23:0];
        f_r[j+1]  <= {f_r[j][LOG_FRAC-2:0], t2[24]};
        ip_r[j+1] <= ip_r[j];
      end
    end
  end

  assign l_out = {ip_r[LOG_FRAC], f_r[LOG_FRAC]};

endmodule

// ===== tb/itr_checker.sv =====
// Result checker for the impedance-to-reflection block: predicts each result and compares.
module itr_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_load_resistance,
  input  logic [31:0] in_load_reactance,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_result_valid,
  input  logic [23:0] out_gamma_real,
  input  logic [23:0] out_gamma_imag,
  input  logic [23:0] out_gamma_magnitude,
  input  logic [24:0] out_phase_degrees,
  input  logic [15:0] out_s11_db,
  input  logic [15:0] out_return_loss_db,
  input  logic [23:0] out_vswr_value,
  input  logic        out_vswr_infinite,
  input  logic        out_perfect_match,
  input  logic        out_saturated,
  output int          fail_count,
  output int          pending_count
);
  import itr_pkg::*;

  localparam int STAGES = 16;
  localparam longint LIM30 = 64'd1073741824;
  localparam longint MAXQ = 64'd16777215;

  typedef struct packed {
    logic        valid;
    logic [23:0] gre;
    logic [23:0] gim;
    logic [23:0] mag;
    logic [24:0] ph;
    logic [15:0] s11;
    logic [15:0] rl;
    logic [23:0] vswr;
    logic        inf;
    logic        pm;
    logic        sat;
  } refl_t;

  // Arctangent of 2^-i in Q16.16 degrees
  localparam longint ATAN_TBL [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0
  };

  refl_t       expected_results[$];
  logic [31:0] z0_shadow;

  function automatic longint unsigned magnitude_of(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint shrink_toward_zero(longint v, int s);
    longint m;
    m = longint'(magnitude_of(v) >> s);
    return (v < 0) ? -m : m;
  endfunction

  // a*2^16/b truncated, 2^24 when the quotient reaches 256
  function automatic longint unsigned div_q16(longint unsigned a, longint unsigned b);
    longint unsigned q, r;
    if (b == 0) return (a == 0) ? 0 : (64'd1 << 24);
    q = a / b;
    if (q >= 256) return 64'd1 << 24;
    r = a % b;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint gamma_component(longint num, longint den, inout bit sat);
    longint v;
    v = longint'(div_q16(magnitude_of(num), longint'(den)));
    if (num < 0) v = -v;
    if (den == 0 && num != 0) sat = 1'b1;
    if (v > 8388607) begin
      v = 8388607;
      sat = 1'b1;
    end
    if (v < -8388608) begin
      v = -8388608;
      sat = 1'b1;
    end
    return v;
  endfunction

  function automatic void vector_polar(longint xi, longint yi, output longint unsigned mag,
                                       output longint ang);
    longint x, y, z, xs, ys;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 11796480;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TBL[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TBL[i];
      end
    end
    mag = longint'(x);
    ang = z;
  endfunction

  // log2 of m/2^16 in Q16
  function automatic longint log2_fixed(longint unsigned m);
    int p;
    longint unsigned t;
    longint frac;
    p = 23;
    frac = 0;
    while (p > 0 && ((m >> p) & 1) == 0) p--;
    t = m << (23 - p);
    for (int k = 15; k >= 0; k--) begin
      t = (t * t) >> 23;
      if (t >= (64'd1 << 24)) begin
        frac = frac | (longint'(1) << k);
        t = t >> 1;
      end
    end
    return longint'(p - 16) * 65536 + frac;
  endfunction

  function automatic refl_t predict_reflection(logic [31:0] r_in, logic [31:0] x_in,
                                               logic [31:0] z0);
    longint n, d, x, gre, gim, ang_a, ang_b, ph, s11, rl;
    longint unsigned mag_a, mag_b, m, vswr;
    int s;
    bit sat, inf, pm;
    refl_t res;
    res = '0;
    sat = 0;
    inf = 0;
    pm = 0;
    s = 0;
    x = longint'(signed'(x_in));
    n = longint'(signed'(r_in)) - longint'(z0);
    d = longint'(signed'(r_in)) + longint'(z0);
    if (z0 == 0 || (d == 0 && x == 0)) return res;
    // Prescale all three terms below 2^30
    while (((magnitude_of(n) | magnitude_of(d) | magnitude_of(x)) >> s) >= LIM30) s++;
    n = shrink_toward_zero(n, s);
    d = shrink_toward_zero(d, s);
    x = shrink_toward_zero(x, s);
    gre = gamma_component(n * d + x * x, d * d + x * x, sat);
    gim = gamma_component(x * d - n * x, d * d + x * x, sat);
    vector_polar(n, x, mag_a, ang_a);
    vector_polar(d, x, mag_b, ang_b);
    m = div_q16(mag_a, mag_b);
    if (mag_b == 0 && mag_a != 0) sat = 1'b1;
    if (m > MAXQ) begin
      m = MAXQ;
      sat = 1'b1;
    end
    ph = ang_a - ang_b;
    while (ph > 11796480) ph = ph - 23592960;
    while (ph <= -11796480) ph = ph + 23592960;
    if (m == 0) begin
      pm = 1'b1;
      s11 = -32768;
      rl = 32767;
    end else begin
      s11 = (log2_fixed(m) * 394566 + (longint'(1) << 23)) >>> 24;
      rl = -s11;
    end
    if (m >= 65536) begin
      inf = 1'b1;
      vswr = MAXQ;
    end else begin
      vswr = ((65536 + m) << 8) / (65536 - m);
      if (vswr > MAXQ) begin
        vswr = MAXQ;
        sat = 1'b1;
      end
    end
    res.valid = 1'b1;
    res.gre = gre[23:0];
    res.gim = gim[23:0];
    res.mag = m[23:0];
    res.ph = ph[24:0];
    res.s11 = s11[15:0];
    res.rl = rl[15:0];
    res.vswr = vswr[23:0];
    res.inf = inf;
    res.pm = pm;
    res.sat = sat;
    return res;
  endfunction

  assign pending_count = expected_results.size();

  // Track Z0, queue predictions, compare each accepted result with the oldest one
  always @(posedge clk) begin
    refl_t got, want;
    if (!rst_n) begin
      z0_shadow <= Z0_RESET;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) z0_shadow <= cfg_data;
      if (in_valid && in_ready)
        expected_results.push_back(predict_reflection(in_load_resistance,
                                                      in_load_reactance, z0_shadow));
      if (out_valid && out_ready) begin
        got = '{out_result_valid, out_gamma_real, out_gamma_imag, out_gamma_magnitude,
                out_phase_degrees, out_s11_db, out_return_loss_db, out_vswr_value,
                out_vswr_infinite, out_perfect_match, out_saturated};
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("ERROR: result transaction with none expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("ERROR: mismatch exp v=%b gr=%h gi=%h m=%h ph=%h s11=%h rl=%h vs=%h f=%b%b%b",
                       want.valid, want.gre, want.gim, want.mag, want.ph, want.s11, want.rl,
                       want.vswr, want.inf, want.pm, want.sat);
              $display("       got      v=%b gr=%h gi=%h m=%h ph=%h s11=%h rl=%h vs=%h f=%b%b%b",
                       got.valid, got.gre, got.gim, got.mag, got.ph, got.s11, got.rl,
                       got.vswr, got.inf, got.pm, got.sat);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
// Testbench top: drives loads and Z0 settings into the reflection block and gives the verdict.
module tb;
  import itr_pkg::*;

  typedef enum int {IDLE_SEND_LIGHT, IDLE_RECV_LIGHT, IDLE_NONE} idle_mode_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 140;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [31:0] in_load_resistance = '0;
  logic signed [31:0] in_load_reactance = '0;
  logic cfg_valid = 1'b0;
  logic [31:0] cfg_data = '0;
  logic out_ready = 1'b0;
  logic in_ready, cfg_ready, out_valid;
  logic out_result_valid, out_vswr_infinite, out_perfect_match, out_saturated;
  logic signed [23:0] out_gamma_real, out_gamma_imag;
  logic [23:0] out_gamma_magnitude, out_vswr_value;
  logic signed [24:0] out_phase_degrees;
  logic signed [15:0] out_s11_db, out_return_loss_db;
  int fail_count, pending_count, cycles;
  idle_mode_t idle_mode = IDLE_SEND_LIGHT;
  logic [31:0] z0_now;

  impedance_to_reflection u_top (.*);

  itr_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_load_resistance, .in_load_reactance,
    .cfg_valid, .cfg_ready, .cfg_data, .out_valid, .out_ready, .out_result_valid,
    .out_gamma_real, .out_gamma_imag, .out_gamma_magnitude, .out_phase_degrees,
    .out_s11_db, .out_return_loss_db, .out_vswr_value, .out_vswr_infinite,
    .out_perfect_match, .out_saturated, .fail_count, .pending_count
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver stalls according to the current idle mode
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_SEND_LIGHT: out_ready <= ($urandom_range(99) >= 51);
      IDLE_RECV_LIGHT: out_ready <= ($urandom_range(99) >= 24);
      default:         out_ready <= 1'b1;
    endcase
  end

  task automatic send_load(logic [31:0] r, logic [31:0] x);
    int idle_pct;
    idle_pct = (idle_mode == IDLE_SEND_LIGHT) ? 24 : (idle_mode == IDLE_RECV_LIGHT) ? 51 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_load_resistance = r;
    in_load_reactance = x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_count != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Write Z0 with the block idle
  task automatic write_z0(logic [31:0] v);
    drain_results();
    cfg_valid = 1'b1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    z0_now = v;
  endtask

  // Random load: mostly near Z0 and small values, some raw 32-bit noise, plus -Z0, extremes and zero
  function automatic logic [31:0] random_field(logic [31:0] z0, bit is_r);
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) return (is_r ? z0 : 32'd0) + $urandom_range(8191) - 4096;
    if (pick < 65) return $urandom;
    if (pick < 85) return $urandom_range(2097151) - 1048576;
    if (pick < 90) return is_r ? -z0 : 32'd0;
    if (pick < 95) return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
    return 32'd0;
  endfunction

  initial begin
    logic [31:0] z0_list [6];
    logic [31:0] r, x;
    z0_list = '{32'd3276800, 32'd1, 32'hFFFFFFFF, 32'h80000001, 32'd4915200, 32'd0};
    z0_list[5] = $urandom_range(32'hFFFFFFFE) + 1;
    z0_now = Z0_RESET;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed loads at the default Z0
    send_load(z0_now, 32'd0);               // perfect match
    send_load(-z0_now, 32'd0);              // load of minus Z0: invalid
    send_load(-z0_now, 32'd1);
    send_load(32'd0, 32'd0);                // short
    send_load(32'h7FFFFFFF, 32'h7FFFFFFF);
    send_load(32'h80000000, 32'h80000000);
    send_load(32'h80000000, 32'h7FFFFFFF);
    send_load(32'h7FFFFFFF, 32'h80000000);
    send_load(32'd0, 32'h7FFFFFFF);
    send_load(-z0_now + 1, 32'd0);          // gamma clips
    send_load(z0_now + 1, 32'hFFFFFFFF);
    send_load(32'hFFFFFFFF, 32'd1);

    for (int p = 0; p < 6; p++) begin
      write_z0(z0_list[p]);
      if (p == 3) send_load(32'h80000000, 32'd1);  // denominator lost in prescale
      send_load(z0_now, 32'd0);
      send_load(-z0_now, 32'd0);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        int k;
        k = p * RANDOM_PER_PHASE + i;
        idle_mode = (k < 280) ? IDLE_SEND_LIGHT : (k < 560) ? IDLE_RECV_LIGHT : IDLE_NONE;
        if (k == 400) drain_results();
        r = random_field(z0_now, 1'b1);
        x = random_field(z0_now, 1'b0);
        send_load(r, x);
      end
    end

    idle_mode = IDLE_NONE;
    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
